@@ sv/scc_pkg.sv @@
// Shared types, constants and the CRC-8 byte update for the scratchpad checker.
// No dependencies; scc_frame, scc_check and sensor_scratchpad_checker import it.
package scc_pkg;

  // Frame position codes for the byte index register.
  localparam logic [3:0] IDX_TEMP_LSB  = 4'd0;
  localparam logic [3:0] IDX_TEMP_MSB  = 4'd1;
  localparam logic [3:0] IDX_HIGH_ALRM = 4'd2;
  localparam logic [3:0] IDX_LOW_ALRM  = 4'd3;
  localparam logic [3:0] IDX_CONFIG    = 4'd4;
  localparam logic [3:0] IDX_CRC_BYTE  = 4'd8;
  localparam logic [3:0] IDX_IDLE      = 4'd9;

  // Reflected 1-Wire CRC-8 polynomial.
  localparam logic [7:0] CRC_POLY = 8'h8C;

  // Raw reading that the sensor reports before its first conversion.
  localparam logic [15:0] POWER_ON_RAW = 16'h0550;

  // Valid range, -55 C to 125 C, in sixteenths of a degree.
  localparam logic signed [15:0] RAW_MIN = -16'sd880;
  localparam logic signed [15:0] RAW_MAX = 16'sd2000;

  // Result status codes, in order of priority.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_POWER_ON = 2'd2,
    ST_RANGE    = 2'd3
  } scc_status_t;

  // Everything the status check needs once a frame closes.
  typedef struct packed {
    logic [7:0] temp_low;
    logic [7:0] temp_high;
    logic [7:0] high_alarm;
    logic [7:0] low_alarm;
    logic [7:0] config_val;
    logic [7:0] computed_crc;
    logic [7:0] received_crc;
  } scc_frame_t;

  // One byte through the CRC, least significant bit first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc_in,
                                             input logic [7:0] data);
    logic [7:0] crc;
    logic [7:0] d;
    logic       mix;
    crc = crc_in;
    d   = data;
    for (int i = 0; i < 8; i++) begin
      mix = crc[0] ^ d[0];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
      d = d >> 1;
    end
    return crc;
  endfunction

endpackage

@@ sv/scc_in_if.sv @@
// Handshake channel carrying one received scratchpad byte per transaction.
// No dependencies.
interface scc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

@@ sv/scc_out_if.sv @@
// Handshake channel carrying one checked scratchpad result per transaction.
// No dependencies.
interface scc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [15:0] temperature_raw;
  logic [7:0]         high_alarm;
  logic [7:0]         low_alarm;
  logic [1:0]         resolution;
  logic [7:0]         computed_crc;

  modport source (output valid, output status, output temperature_raw,
                  output high_alarm, output low_alarm, output resolution,
                  output computed_crc, input ready);
  modport sink   (input valid, input status, input temperature_raw,
                  input high_alarm, input low_alarm, input resolution,
                  input computed_crc, output ready);
endinterface

@@ sv/scc_frame.sv @@
// Input register, frame tracking, byte capture and running CRC.
// Depends on scc_pkg and scc_in_if.
module scc_frame
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  scc_in_if.sink     scratchpad,
  input  logic       out_free,
  output logic       frame_done,
  output scc_frame_t frame
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_first;
  logic [3:0] byte_index;
  logic [7:0] running_crc;
  logic [7:0] temp_low_byte;
  logic [7:0] temp_high_byte;
  logic [7:0] high_alarm_byte;
  logic [7:0] low_alarm_byte;
  logic [7:0] config_byte;

  logic [3:0] idx_eff;
  logic [7:0] crc_base;
  logic [7:0] crc_next;
  logic       active;
  logic       last;
  logic       advance;

  // A marked first byte reopens the frame at byte 0 with a cleared CRC.
  always_comb begin
    idx_eff  = s1_first ? IDX_TEMP_LSB : byte_index;
    crc_base = s1_first ? 8'h00 : running_crc;
    crc_next = crc8_update(crc_base, s1_byte);
    active   = (idx_eff < IDX_IDLE);
    last     = (idx_eff == IDX_CRC_BYTE);
  end

  // The held byte moves on unless it closes a frame and the result register is full.
  assign advance          = s1_valid && (!(active && last) || out_free);
  assign frame_done       = s1_valid && active && last && out_free;
  assign scratchpad.ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scratchpad.ready) begin
      s1_valid <= scratchpad.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scratchpad.ready && scratchpad.valid) begin
      s1_byte  <= scratchpad.data_byte;
      s1_first <= scratchpad.first_byte;
    end
  end

  // Frame position and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= IDX_IDLE;
      running_crc <= 8'h00;
    end else if (advance && active) begin
      if (last) begin
        byte_index <= IDX_IDLE;
      end else begin
        byte_index  <= idx_eff + 4'd1;
        running_crc <= crc_next;
      end
    end
  end

  // Keep the first five bytes of the frame.
  always_ff @(posedge clk) begin
    if (advance && active) begin
      case (idx_eff)
        IDX_TEMP_LSB:  temp_low_byte   <= s1_byte;
        IDX_TEMP_MSB:  temp_high_byte  <= s1_byte;
        IDX_HIGH_ALRM: high_alarm_byte <= s1_byte;
        IDX_LOW_ALRM:  low_alarm_byte  <= s1_byte;
        IDX_CONFIG:    config_byte     <= s1_byte;
        default: ;
      endcase
    end
  end

  // Closed frame handed to the status check.
  always_comb begin
    frame.temp_low     = temp_low_byte;
    frame.temp_high    = temp_high_byte;
    frame.high_alarm   = high_alarm_byte;
    frame.low_alarm    = low_alarm_byte;
    frame.config_val   = config_byte;
    frame.computed_crc = running_crc;
    frame.received_crc = s1_byte;
  end

`ifndef SYNTHESIS
  a_index_range : assert property (@(posedge clk) disable iff (rst)
    byte_index <= IDX_IDLE)
    else $error("byte index beyond the idle code");

  a_done_closes : assert property (@(posedge clk) disable iff (rst)
    frame_done |=> byte_index == IDX_IDLE)
    else $error("frame still open after its result was issued");

  a_first_opens : assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_first && advance |=> byte_index == IDX_TEMP_MSB)
    else $error("first byte did not open a new frame");
`endif

endmodule

@@ sv/scc_check.sv @@
// Status decision and result register for a closed scratchpad frame.
// Depends on scc_pkg and scc_out_if.
module scc_check
  import scc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       frame_done,
  input  scc_frame_t frame,
  output logic       out_free,
  scc_out_if.source  result
);

  logic [15:0]        raw;
  logic signed [15:0] sraw;
  scc_status_t        status_next;

  // Checks in priority order: CRC, power-on default, then range.
  always_comb begin
    raw  = {frame.temp_high, frame.temp_low};
    sraw = signed'(raw);
    if (frame.computed_crc != frame.received_crc) begin
      status_next = ST_CRC_ERR;
    end else if (raw == POWER_ON_RAW) begin
      status_next = ST_POWER_ON;
    end else if (sraw < RAW_MIN || sraw > RAW_MAX) begin
      status_next = ST_RANGE;
    end else begin
      status_next = ST_OK;
    end
  end

  assign out_free = !result.valid || result.ready;

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (frame_done) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (frame_done) begin
      result.status          <= status_next;
      result.temperature_raw <= sraw;
      result.high_alarm      <= frame.high_alarm;
      result.low_alarm       <= frame.low_alarm;
      result.resolution      <= frame.config_val[6:5];
      result.computed_crc    <= frame.computed_crc;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    frame_done |-> out_free)
    else $error("closed frame would overwrite a pending result");

  a_ok_in_range : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_OK |->
      result.temperature_raw >= RAW_MIN && result.temperature_raw <= RAW_MAX)
    else $error("status ok with temperature out of range");

  a_ok_not_default : assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status == ST_OK |->
      result.temperature_raw != signed'(POWER_ON_RAW))
    else $error("status ok on the power-on default reading");
`endif

endmodule

@@ sv/sensor_scratchpad_checker.sv @@
// Top level of the scratchpad checker: joins frame tracking and status check.
// Depends on scc_pkg, scc_in_if, scc_out_if, scc_frame and scc_check.
//
// Takes one scratchpad byte per transaction on the input channel and sustains one
// byte per clock cycle unless a closing byte waits. A byte marked as first opens
// a new frame. Bytes 0 to 7 pass through the unrolled eight-step CRC update while
// they sit in the input register. The ninth byte of the frame goes from the input
// register, where the status compare runs, into the result register. Bytes
// outside a frame give no result.
// While a result waits in the result register the block still takes bytes; only a
// byte that closes a frame waits, holding the input register, until the result has
// been taken.
module sensor_scratchpad_checker
  import scc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  scc_in_if.sink    scratchpad,
  scc_out_if.source result
);

  logic       frame_done;
  logic       out_free;
  scc_frame_t frame;

  scc_frame u_frame (
    .clk        (clk),
    .rst        (rst),
    .scratchpad (scratchpad),
    .out_free   (out_free),
    .frame_done (frame_done),
    .frame      (frame)
  );

  scc_check u_check (
    .clk        (clk),
    .rst        (rst),
    .frame_done (frame_done),
    .frame      (frame),
    .out_free   (out_free),
    .result     (result)
  );

endmodule

@@ bench/tb_sensor_scratchpad_checker.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the scratchpad checker: drives scratchpad bytes, predicts each
// frame result and compares it with the result channel. Depends on scc_pkg, scc_in_if,
// scc_out_if and sensor_scratchpad_checker.
module tb_sensor_scratchpad_checker;
  import scc_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LONG_HOLD      = 150;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [2:0] {
    PH_STEADY,
    PH_SOURCE_GAPS,
    PH_SINK_STALLS,
    PH_BOTH,
    PH_BACKPRESSURE
  } bench_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } scratch_byte_t;

  typedef struct packed {
    scc_status_t        status;
    logic signed [15:0] temp;
    logic [7:0]         th;
    logic [7:0]         tl;
    logic [1:0]         res;
    logic [7:0]         crc;
  } scratch_result_t;

  logic clk;
  logic rst;

  scc_in_if  in_ch ();
  scc_out_if out_ch ();

  sensor_scratchpad_checker dut (
    .clk        (clk),
    .rst        (rst),
    .scratchpad (in_ch),
    .result     (out_ch)
  );

  // Bytes waiting to be offered, and results still owed by the block.
  scratch_byte_t   byte_queue[$];
  scratch_result_t result_queue[$];

  int src_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int frame_bytes   = 0;
  int mismatches    = 0;
  int idle_cycles   = 0;
  int hold_left     = 0;
  bit hold_wanted   = 0;
  bit hold_started  = 0;
  bench_phase_t phase = PH_STEADY;

  // Predictor state: frame position, running CRC and the kept scratchpad bytes.
  logic [3:0] frame_pos = IDX_IDLE;
  logic [7:0] frame_crc = 8'h00;
  logic [7:0] kept_lo, kept_hi, kept_th, kept_tl, kept_cfg;

  scratch_byte_t next_byte;
  logic          in_take;

  // Reflected CRC-8, one data bit per step, least significant bit first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Advances the predictor by one accepted byte and queues the result a closing byte causes.
  task automatic predict_byte(input logic [7:0] b, input logic first);
    scratch_result_t    r;
    logic signed [15:0] sraw;
    if (first) begin
      frame_pos = IDX_TEMP_LSB;
      frame_crc = 8'h00;
    end
    if (frame_pos > IDX_CRC_BYTE) begin
      return;
    end
    case (frame_pos)
      IDX_TEMP_LSB:  kept_lo  = b;
      IDX_TEMP_MSB:  kept_hi  = b;
      IDX_HIGH_ALRM: kept_th  = b;
      IDX_LOW_ALRM:  kept_tl  = b;
      IDX_CONFIG:    kept_cfg = b;
      default: ;
    endcase
    if (frame_pos != IDX_CRC_BYTE) begin
      frame_crc = crc_step(frame_crc, b);
      frame_pos = frame_pos + 4'd1;
    end else begin
      frame_pos = IDX_IDLE;
      sraw      = {kept_hi, kept_lo};
      if (frame_crc != b) begin
        r.status = ST_CRC_ERR;
      end else if ({kept_hi, kept_lo} == POWER_ON_RAW) begin
        r.status = ST_POWER_ON;
      end else if (sraw < RAW_MIN || sraw > RAW_MAX) begin
        r.status = ST_RANGE;
      end else begin
        r.status = ST_OK;
      end
      r.temp = sraw;
      r.th   = kept_th;
      r.tl   = kept_tl;
      r.res  = kept_cfg[6:5];
      r.crc  = frame_crc;
      result_queue.push_back(r);
    end
  endtask

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_byte(input logic [7:0] data, input logic first);
    scratch_byte_t sb;
    sb.data  = data;
    sb.first = first;
    byte_queue.push_back(sb);
  endtask

  // Queues the first n_bytes of a frame; the ninth byte carries a good or a corrupted CRC.
  task automatic push_frame(input logic [15:0] raw, input logic [7:0] th, input logic [7:0] tl,
                            input logic [7:0] cfg, input bit crc_good, input int n_bytes);
    logic [7:0] fb[9];
    logic [7:0] c;
    fb[0] = raw[7:0];
    fb[1] = raw[15:8];
    fb[2] = th;
    fb[3] = tl;
    fb[4] = cfg;
    for (int i = 5; i < 8; i++) begin
      fb[i] = 8'($urandom_range(255));
    end
    c = 8'h00;
    for (int i = 0; i < 8; i++) begin
      c = crc_step(c, fb[i]);
    end
    fb[8] = crc_good ? c : c ^ 8'($urandom_range(255, 1));
    for (int i = 0; i < n_bytes; i++) begin
      push_byte(fb[i], i == 0);
    end
    frame_bytes += n_bytes;
  endtask

  // Temperature readings weighted towards the status boundaries.
  function automatic logic [15:0] pick_raw();
    int v;
    case ($urandom_range(11))
      0:       return POWER_ON_RAW;
      1:       return 16'(RAW_MAX);
      2:       return 16'(RAW_MAX + 1);
      3:       return 16'(RAW_MIN);
      4:       return 16'(RAW_MIN - 1);
      5:       return 16'h8000;
      6:       return 16'h7FFF;
      7, 8:    return 16'($urandom_range(65535));
      default: begin
        v = $urandom_range(2880);
        v = v - 880;
        return v[15:0];
      end
    endcase
  endfunction

  // Mostly well-formed frames, with stray bytes and cut-short frames mixed in.
  task automatic fill_random(input int n);
    int target;
    int r;
    target = frame_bytes + n;
    while (frame_bytes < target) begin
      r = $urandom_range(99);
      if (r < 8) begin
        repeat ($urandom_range(3, 1)) begin
          push_byte(8'($urandom_range(255)), 1'b0);
        end
      end else if (r < 18) begin
        push_frame(pick_raw(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 1'b1, $urandom_range(8, 1));
      end else begin
        push_frame(pick_raw(), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), $urandom_range(99) < 80, 9);
      end
    end
  endtask

  task automatic wait_queue_empty();
    while (byte_queue.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic enter_phase(input bench_phase_t p, input int idle_pct, input int stall_pct);
    phase         = p;
    src_idle_pct  = idle_pct;
    rcv_stall_pct = stall_pct;
  endtask

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver: holds each byte until the block accepts it and predicts on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid      <= 1'b0;
      in_ch.data_byte  <= 8'h00;
      in_ch.first_byte <= 1'b0;
    end else begin
      in_take = in_ch.valid && in_ch.ready;
      if (in_take) begin
        predict_byte(in_ch.data_byte, in_ch.first_byte);
      end
      if (!in_ch.valid || in_take) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          next_byte = byte_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.data_byte  <= next_byte.data;
          in_ch.first_byte <= next_byte.first;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, plus one long hold-off while bytes keep coming.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_wanted && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= LONG_HOLD;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // Result monitor: compares each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d temperature %h",
                 $time, out_ch.status, out_ch.temperature_raw);
        mismatches++;
      end else begin
        check_field("status", 16'(result_queue[0].status), 16'(out_ch.status));
        check_field("temperature_raw", result_queue[0].temp, out_ch.temperature_raw);
        check_field("high_alarm", 16'(result_queue[0].th), 16'(out_ch.high_alarm));
        check_field("low_alarm", 16'(result_queue[0].tl), 16'(out_ch.low_alarm));
        check_field("resolution", 16'(result_queue[0].res), 16'(out_ch.resolution));
        check_field("computed_crc", 16'(result_queue[0].crc), 16'(out_ch.computed_crc));
        void'(result_queue.pop_front());
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, result_queue.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst              = 1'b1;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = 8'h00;
    in_ch.first_byte = 1'b0;
    out_ch.ready     = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: stray byte, cut-short frame, power-on reading, byte after a frame,
    // most negative reading with the top resolution.
    enter_phase(PH_STEADY, 0, 0);
    push_byte(8'hFF, 1'b0);
    push_frame(16'h0190, 8'h00, 8'hFF, 8'h1F, 1'b1, 3);
    push_frame(POWER_ON_RAW, 8'h4B, 8'h46, 8'h7F, 1'b1, 9);
    push_byte(8'h00, 1'b0);
    push_frame(16'h8000, 8'hFF, 8'h00, 8'h60, 1'b1, 9);
    fill_random(110);
    wait_queue_empty();

    enter_phase(PH_SOURCE_GAPS, 57, 0);
    fill_random(110);
    wait_queue_empty();

    enter_phase(PH_SINK_STALLS, 0, 57);
    fill_random(110);
    wait_queue_empty();

    enter_phase(PH_BOTH, 19, 19);
    fill_random(110);
    wait_queue_empty();

    enter_phase(PH_BACKPRESSURE, 0, 0);
    fill_random(60);
    hold_wanted = 1'b1;
    wait_queue_empty();

    while (in_ch.valid || result_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/scc_pkg.sv
sv/scc_in_if.sv
sv/scc_out_if.sv
sv/scc_frame.sv
sv/scc_check.sv
sv/sensor_scratchpad_checker.sv
bench/tb_sensor_scratchpad_checker.sv
